@@ src/cwag_pkg.sv @@
// Shared stage record and constants for the cylindrical warp address generator.
package cwag_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FOCAL  = 2'd2
  } cfg_idx_t;

  localparam int TAYLOR_TERMS = 6;

  // One record travels down the cell chain; each cell rewrites the fields it owns.
  typedef struct packed {
    logic              bad;      // angle out of range or zero focal length
    logic              neg;      // sign of the horizontal offset
    logic signed [12:0] dy;      // vertical offset from the center row
    logic [36:0]       urem;     // remainder of the angle division
    logic [16:0]       umag;     // |u| in Q1.17
    logic [29:0]       u2;       // u^2 in Q2.30
    logic [30:0]       smag;     // |current sine term|
    logic [30:0]       cmag;     // |current cosine term|
    logic [30:0]       sprod;    // sine term times u^2
    logic [30:0]       cprod;    // cosine term times u^2
    logic [30:0]       sq0;      // sine quotient estimate
    logic [30:0]       cq0;      // cosine quotient estimate
    logic signed [31:0] ssum;    // sine sum, Q2.30
    logic signed [31:0] csum;    // cosine sum, Q2.30
    logic [34:0]       sq_v;     // square root remainder
    logic [34:0]       sq_r;     // square root partial result
    logic [46:0]       trem;     // tangent division remainder
    logic [30:0]       tdiv;     // tangent divisor (cosine sum)
    logic [17:0]       tq;       // |tan| quotient, Q2.16
    logic              tneg;     // sign of tan
    logic [33:0]       srem;     // secant division remainder
    logic [17:0]       root;     // sqrt(1 - u^2), Q.17
    logic [17:0]       secq;     // secant quotient, Q2.16
    logic              ssat;     // secant saturates
    logic signed [39:0] px;      // focal times tan
    logic signed [31:0] py;      // dy times secant
  } stage_t;

endpackage

@@ src/cwag_udiv_cell.sv @@
// One restoring step of the angle division |u| = |dx| * 2^25 / focal.
module cwag_udiv_cell import cwag_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  stage_t      in_st,
  input  logic [19:0] focal,
  output logic        out_valid,
  output stage_t      out_st
);

  logic   valid_r;
  stage_t st_r, st_nxt;
  logic [36:0] fdiv;

  always_comb begin
    st_nxt = in_st;
    fdiv   = 37'(focal) << BIT;
    if (in_st.urem >= fdiv) begin
      st_nxt.urem      = in_st.urem - fdiv;
      st_nxt.umag[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

@@ src/cwag_series_cell.sv @@
// One phase of a Taylor term for sin and cos, plus one step of the square root.
module cwag_series_cell import cwag_pkg::*; #(
  parameter int TERM  = 1,
  parameter int PHASE = 0,
  parameter int SQB   = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  stage_t in_st,
  output logic   out_valid,
  output stage_t out_st
);

  localparam int          DS = 2 * TERM * (2 * TERM + 1);
  localparam int          DC = (2 * TERM - 1) * 2 * TERM;
  localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
  localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
  localparam logic        ODD = 1'((TERM % 2) == 1);

  logic   valid_r;
  stage_t st_r, st_nxt;
  logic [60:0] ps, pc;
  logic [62:0] ms, mc;
  logic [38:0] qds, qdc, rs, rc;
  logic [30:0] qs, qc;
  logic [34:0] bitv;
  logic [35:0] trial;

  always_comb begin
    st_nxt = in_st;
    ps     = 61'(in_st.smag) * 61'(in_st.u2);
    pc     = 61'(in_st.cmag) * 61'(in_st.u2);
    ms     = 63'(in_st.sprod) * 63'(MS);
    mc     = 63'(in_st.cprod) * 63'(MC);
    qds    = 39'(in_st.sq0) * 39'(DS);
    qdc    = 39'(in_st.cq0) * 39'(DC);
    rs     = 39'(in_st.sprod) - qds;
    rc     = 39'(in_st.cprod) - qdc;
    qs     = (rs >= 39'(DS)) ? in_st.sq0 + 31'd1 : in_st.sq0;
    qc     = (rc >= 39'(DC)) ? in_st.cq0 + 31'd1 : in_st.cq0;
    if (PHASE == 0) begin
      st_nxt.sprod = ps[60:30];
      st_nxt.cprod = pc[60:30];
    end else if (PHASE == 1) begin
      // Reciprocal estimate, low by at most one.
      st_nxt.sq0 = ms[62:32];
      st_nxt.cq0 = mc[62:32];
    end else begin
      st_nxt.smag = qs;
      st_nxt.cmag = qc;
      st_nxt.ssum = (in_st.neg ^ ODD) ? in_st.ssum - $signed({1'b0, qs})
                                      : in_st.ssum + $signed({1'b0, qs});
      st_nxt.csum = ODD ? in_st.csum - $signed({1'b0, qc})
                        : in_st.csum + $signed({1'b0, qc});
    end
    // Digit-by-digit integer square root step.
    bitv  = 35'(1) << SQB;
    trial = 36'(in_st.sq_r) + 36'(bitv);
    if (36'(in_st.sq_v) >= trial) begin
      st_nxt.sq_v = in_st.sq_v - trial[34:0];
      st_nxt.sq_r = (in_st.sq_r >> 1) + bitv;
    end else begin
      st_nxt.sq_r = in_st.sq_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

@@ src/cwag_qdiv_cell.sv @@
// One restoring step of both the tangent and the secant divisions.
module cwag_qdiv_cell import cwag_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  stage_t in_st,
  output logic   out_valid,
  output stage_t out_st
);

  logic   valid_r;
  stage_t st_r, st_nxt;
  logic [47:0] tdivs;
  logic [34:0] sdivs;

  always_comb begin
    st_nxt = in_st;
    tdivs  = 48'(in_st.tdiv) << BIT;
    sdivs  = 35'(in_st.root) << BIT;
    if (48'(in_st.trem) >= tdivs) begin
      st_nxt.trem    = in_st.trem - tdivs[46:0];
      st_nxt.tq[BIT] = 1'b1;
    end
    if (35'(in_st.srem) >= sdivs) begin
      st_nxt.srem      = in_st.srem - sdivs[33:0];
      st_nxt.secq[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

@@ src/cylindrical_warp_address_gen.sv @@
// Top level of the cylindrical inverse warp address generator.
//
// Channel   Direction  Beat contents
// in_       slave      tdata[10:0] dst_x, tdata[21:11] dst_y
// out_      master     tdata[15:0] src_x, tdata[31:16] src_y, tuser in_range
// cfg_      slave      cfg_index register, cfg_data value
//
// Every beat passes through a chain of 57 registered cells and then the output
// register. The chain takes a new beat in every cycle in which it advances; its
// length is set by the three bit-serial divisions (angle, tangent, secant) and the
// six Taylor terms, each cell doing one quotient bit or one phase of a term. Reset
// is synchronous and active low; it empties the chain and reloads the default
// image geometry. When the output register is held by the sink, the chain still
// moves as long as its last cell is empty, so bubbles close up before the input
// is stalled.
module cylindrical_warp_address_gen import cwag_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [10:0] dst_x, [21:11] dst_y, [23:22] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] src_x, [31:16] src_y
  output logic        out_tuser,  // [0] in_range
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int NST = 57;   // number of registered stages ahead of the output
  localparam int UDIV0 = 0;  // first angle division cell
  localparam int SER0 = 18;  // first series cell
  localparam int QDIV0 = 37; // first tangent/secant division cell

  // Configuration registers.
  logic [11:0] width_r, height_r;
  logic [19:0] focal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 12'd480;
      focal_r  <= 20'd197773;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data[11:0];
        CFG_HEIGHT: height_r <= cfg_data[11:0];
        CFG_FOCAL:  focal_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Clamped geometry and the image center. The user must change the registers only
  // while the block is idle; the block does not enforce this. Every stage reads them directly.
  logic [11:0] wc, hc;
  logic [10:0] cx, cy;

  assign wc = ({20'd0, width_r} > MAX_WIDTH) ? 12'(MAX_WIDTH) : width_r;
  assign hc = ({20'd0, height_r} > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : height_r;
  assign cx = wc[11:1];
  assign cy = hc[11:1];

  // Chain of stage records.
  stage_t st [NST];
  logic   vld [NST];
  logic   adv;
  logic   out_load;

  assign out_load  = !out_tvalid || out_tready;
  assign adv       = out_load || !vld[NST-1];
  assign in_tready = adv;

  // Input stage: offsets from the center and the range check of the angle.
  stage_t s0_r, s0_nxt;
  logic   v0_r;
  logic signed [12:0] dx;
  logic [11:0] absdx;

  always_comb begin
    s0_nxt = '0;
    dx     = $signed({2'b00, in_tdata[10:0]}) - $signed({2'b00, cx});
    absdx  = dx[12] ? 12'(-dx) : dx[11:0];
    s0_nxt.neg  = dx[12];
    s0_nxt.dy   = $signed({2'b00, in_tdata[21:11]}) - $signed({2'b00, cy});
    s0_nxt.urem = {absdx, 25'd0};
    // |u| of one or more, or a zero focal length, gives the black result.
    s0_nxt.bad  = (focal_r == 20'd0) || ({absdx, 25'd0} >= {focal_r, 17'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
    if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  assign st[0]  = s0_r;
  assign vld[0] = v0_r;

  // Angle division, one quotient bit per cell, most significant first.
  for (genvar i = 0; i < 17; i++) begin : g_udiv
    cwag_udiv_cell #(.BIT(16 - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (vld[UDIV0 + i]),
      .in_st    (st[UDIV0 + i]),
      .focal    (focal_r),
      .out_valid(vld[UDIV0 + i + 1]),
      .out_st   (st[UDIV0 + i + 1])
    );
  end

  // Seed stage for the series and the square root.
  stage_t sb_r, sb_nxt;
  logic   vb_r;
  logic [33:0] usq;

  always_comb begin
    sb_nxt      = st[17];
    usq         = 34'(st[17].umag) * 34'(st[17].umag);
    sb_nxt.u2   = usq[33:4];
    sb_nxt.smag = {st[17].umag, 13'd0} + 31'd0;
    sb_nxt.cmag = 31'h4000_0000;
    sb_nxt.ssum = st[17].neg ? -$signed({2'b00, st[17].umag, 13'd0})
                             : $signed({2'b00, st[17].umag, 13'd0});
    sb_nxt.csum = 32'sh4000_0000;
    sb_nxt.sq_v = 35'(35'h4_0000_0000 - 35'(usq));
    sb_nxt.sq_r = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= vld[17];
    end
    if (adv) begin
      sb_r <= sb_nxt;
    end
  end

  assign st[SER0]  = sb_r;
  assign vld[SER0] = vb_r;

  // Six Taylor terms of three phases each; the root takes one bit pair per cell.
  for (genvar j = 0; j < 3 * TAYLOR_TERMS; j++) begin : g_series
    cwag_series_cell #(
      .TERM (j / 3 + 1),
      .PHASE(j % 3),
      .SQB  (2 * (17 - j))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (vld[SER0 + j]),
      .in_st    (st[SER0 + j]),
      .out_valid(vld[SER0 + j + 1]),
      .out_st   (st[SER0 + j + 1])
    );
  end

  // Division setup: tan = sin * 2^16 / cos and sec = 2^33 / root.
  stage_t sd_r, sd_nxt;
  logic   vd_r;
  logic [30:0] abs_s;

  always_comb begin
    sd_nxt      = st[36];
    abs_s       = st[36].ssum[31] ? 31'(-st[36].ssum) : st[36].ssum[30:0];
    sd_nxt.trem = {abs_s, 16'd0};
    sd_nxt.tdiv = (st[36].csum <= 0) ? 31'd1 : st[36].csum[30:0];
    sd_nxt.tneg = st[36].ssum[31];
    sd_nxt.tq   = '0;
    sd_nxt.root = st[36].sq_r[17:0];
    sd_nxt.srem = 34'h2_0000_0000;
    sd_nxt.secq = '0;
    // The secant reaches 2^18 or more exactly when the root is at most 2^15.
    sd_nxt.ssat = (st[36].sq_r[17:0] <= 18'h0_8000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (adv) begin
      vd_r <= vld[36];
    end
    if (adv) begin
      sd_r <= sd_nxt;
    end
  end

  assign st[QDIV0]  = sd_r;
  assign vld[QDIV0] = vd_r;

  for (genvar k = 0; k < 18; k++) begin : g_qdiv
    cwag_qdiv_cell #(.BIT(17 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (vld[QDIV0 + k]),
      .in_st    (st[QDIV0 + k]),
      .out_valid(vld[QDIV0 + k + 1]),
      .out_st   (st[QDIV0 + k + 1])
    );
  end

  // Products: focal times tan and dy times secant.
  stage_t se_r, se_nxt;
  logic   ve_r;
  logic signed [18:0] tan_s, sec_s;
  logic signed [20:0] focal_s;

  always_comb begin
    se_nxt  = st[55];
    tan_s   = st[55].tneg ? -$signed({1'b0, st[55].tq}) : $signed({1'b0, st[55].tq});
    sec_s   = st[55].ssat ? 19'sh3_FFFF : $signed({1'b0, st[55].secq});
    focal_s = $signed({1'b0, focal_r});
    se_nxt.px = focal_s * tan_s;
    se_nxt.py = st[55].dy * sec_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= vld[55];
    end
    if (adv) begin
      se_r <= se_nxt;
    end
  end

  assign st[56]  = se_r;
  assign vld[56] = ve_r;

  // Final stage: add the center, truncate toward zero, saturate, range check.
  function automatic logic [15:0] sat16(input logic signed [41:0] v);
    if (v > 42'sd32767) begin
      return 16'h7FFF;
    end else if (v < -42'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  logic signed [41:0] ax, ay, qx, qy;
  logic [15:0] sx, sy;
  logic        ok;
  logic [31:0] tdata_nxt;
  logic        tuser_nxt;

  always_comb begin
    ax = $signed({{2{st[56].px[39]}}, st[56].px}) + $signed({7'd0, cx, 24'd0});
    ay = $signed({{10{st[56].py[31]}}, st[56].py}) + $signed({15'd0, cy, 16'd0});
    qx = ax[41] ? (ax + 42'sd16777215) >>> 24 : ax >>> 24;
    qy = ay[41] ? (ay + 42'sd65535) >>> 16 : ay >>> 16;
    sx = sat16(qx);
    sy = sat16(qy);
    ok = !sx[15] && (sx[14:0] < {3'd0, wc}) && !sy[15] && (sy[14:0] < {3'd0, hc});
    if (st[56].bad) begin
      tdata_nxt = '0;
      tuser_nxt = 1'b0;
    end else begin
      tdata_nxt = {sy, sx};
      tuser_nxt = ok;
    end
  end

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld[56];
    end
    if (out_load) begin
      out_data_r <= tdata_nxt;
      out_user_r <= tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A full last cell behind a stalled output must hold the whole chain.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[NST-1] && out_tvalid && !out_tready) |-> !in_tready)
    else $error("chain advanced into a stalled output register");

  // An accepted beat must occupy the first cell on the next edge.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld[0])
    else $error("accepted beat lost at the chain entry");

  // A source inside the image never has a negative coordinate.
  a_in_range_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (!out_tdata[15] && !out_tdata[31]))
    else $error("in-range result with negative coordinate");

endmodule

@@ verif/cylindrical_warp_address_gen_tb.sv @@
// Self-checking testbench for the cylindrical inverse warp address generator.
`timescale 1ns / 1ps

module cylindrical_warp_address_gen_tb;
  import cwag_pkg::*;

  // Pipeline depth from the top-level header, plus some slack for draining.
  localparam int PIPE_DEPTH  = 58;
  localparam int DRAIN_WAIT  = PIPE_DEPTH + 12;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_W       = 2048;
  localparam int MAX_H       = 2048;

  // One source address as the block reports it.
  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               ok;
  } src_addr_t;

  // A directed stimulus row; the expectation is used only when fixed is set.
  typedef struct {
    logic [10:0] x;
    logic [10:0] y;
    bit          fixed;
    src_addr_t   addr;
  } warp_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  // Shadow copy of the geometry registers, kept in step with every write.
  logic [11:0] geo_width;
  logic [11:0] geo_height;
  logic [19:0] geo_focal;

  src_addr_t pending_src[$];
  bit        fixed_flag[$];
  src_addr_t fixed_addr[$];

  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  cylindrical_warp_address_gen dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q2.30 product, truncated toward zero.
  function automatic longint mul_q30(longint a, longint b);
    return (a * b) / 64'sd1073741824;
  endfunction

  // tan(u) in Q2.16 from Taylor series of sine and cosine in Q2.30.
  function automatic longint tangent_q16(longint u17);
    longint u30, u2, st, ssum, ct, csum;
    u30  = u17 * 8192;
    u2   = mul_q30(u30, u30);
    st   = u30;
    ssum = u30;
    ct   = 64'sd1073741824;
    csum = ct;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      st   = -(mul_q30(st, u2) / ((2 * k) * (2 * k + 1)));
      ssum += st;
      ct   = -(mul_q30(ct, u2) / ((2 * k - 1) * (2 * k)));
      csum += ct;
    end
    if (csum <= 0) csum = 1;
    return (ssum * 65536) / csum;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // sec(asin(u)) in Q2.16, saturated to 18 bits.
  function automatic longint secant_q16(longint u17);
    longint unsigned s, r, q;
    s = (64'd1 << 34) - longint'(u17 * u17);
    r = int_sqrt(s);
    if (r == 0) return 262143;
    q = (64'd1 << 33) / r;
    if (q > 262143) q = 262143;
    return longint'(q);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Source address of one destination pixel under the current geometry.
  function automatic src_addr_t warp_source(logic [10:0] x, logic [10:0] y);
    src_addr_t a;
    longint w, h, f, cx, cy, dx, dy, u, t, sc, sx, sy;
    a.sx = '0;
    a.sy = '0;
    a.ok = 1'b0;
    w = (geo_width > MAX_W) ? MAX_W : geo_width;
    h = (geo_height > MAX_H) ? MAX_H : geo_height;
    f = geo_focal;
    cx = w / 2;
    cy = h / 2;
    dx = longint'(x) - cx;
    dy = longint'(y) - cy;
    // Zero focal length and |u| of one or more both give the black result.
    if (f == 0) return a;
    u = (dx * (64'sd1 << 25)) / f;
    if (u >= (64'sd1 << 17) || u <= -(64'sd1 << 17)) return a;
    t  = tangent_q16(u);
    sc = secant_q16(u);
    sx = clip16((f * t + cx * (64'sd1 << 24)) / (64'sd1 << 24));
    sy = clip16((dy * sc + cy * 65536) / 65536);
    a.sx = sx[15:0];
    a.sy = sy[15:0];
    a.ok = (sx >= 0 && sx < w && sy >= 0 && sy < h);
    return a;
  endfunction

  // Receiver: stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts at each accepted input beat and checks each result beat.
  always @(posedge clk) begin
    src_addr_t exp_a, got;
    bit        fx;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_src.push_back(warp_source(in_tdata[10:0], in_tdata[21:11]));
      end
      if (out_tvalid && out_tready) begin
        got.sx = out_tdata[15:0];
        got.sy = out_tdata[31:16];
        got.ok = out_tuser;
        if (pending_src.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: src_x=%0d src_y=%0d ok=%0b",
                                     got.sx, got.sy, got.ok);
        end else begin
          exp_a = pending_src.pop_front();
          fx = 1'b0;
          if (fixed_flag.size() > 0) begin
            fx = fixed_flag.pop_front();
            if (fx) exp_a = fixed_addr.pop_front();
          end
          if (got.sx !== exp_a.sx || got.sy !== exp_a.sy || got.ok !== exp_a.ok) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected src_x=%0d src_y=%0d ok=%0b, got %0d %0d %0b",
                       exp_a.sx, exp_a.sy, exp_a.ok, got.sx, got.sy, got.ok);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sends one destination beat, with random idle cycles ahead of it.
  task automatic send_pixel(logic [10:0] x, logic [10:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(cfg_idx_t idx, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WIDTH: begin
        geo_width = value[11:0];
      end
      CFG_HEIGHT: begin
        geo_height = value[11:0];
      end
      default: begin
        geo_focal = value;
      end
    endcase
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_src.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [19:0] f);
    write_reg(CFG_WIDTH, {8'd0, w});
    write_reg(CFG_HEIGHT, {8'd0, h});
    write_reg(CFG_FOCAL, f);
    cfg_valid <= 1'b0;
  endtask

  // Random beats: most aim inside the valid angle around the center column,
  // the rest spread over the whole field so every bit toggles.
  task automatic send_random(int count);
    int span, cx, xv;
    for (int i = 0; i < count; i++) begin
      cx = ((geo_width > MAX_W) ? MAX_W : geo_width) / 2;
      span = geo_focal >> 8;
      if (span < 1) span = 1;
      if (span > 2047) span = 2047;
      if ($urandom_range(3) != 0) begin
        xv = cx + $urandom_range(2 * span) - span;
        if (xv < 0) xv = 0;
        if (xv > 2047) xv = 2047;
      end else begin
        xv = $urandom_range(2047);
      end
      send_pixel(xv[10:0], 11'($urandom_range(2047)));
    end
  endtask

  task automatic set_pace(int phase);
    case (phase % 4)
      0: begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 64; recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0; recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct = 29; recv_stall_pct = 29;
      end
    endcase
  endtask

  warp_row_t directed[$];

  initial begin
    src_addr_t zero_a;
    zero_a = '{sx: 16'sd0, sy: 16'sd0, ok: 1'b0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    geo_width = 12'd640;
    geo_height = 12'd480;
    geo_focal = 20'd197773;

    // Reset geometry: center is (320, 240), focal about 772.6 pixels.
    // Columns far right of the center exceed the valid angle and come back black.
    directed = '{
      '{11'd320, 11'd240, 1'b1, '{16'sd320, 16'sd240, 1'b1}},
      '{11'd320, 11'd0,   1'b0, zero_a},
      '{11'd320, 11'd2047, 1'b0, zero_a},
      '{11'd0,   11'd0,   1'b0, zero_a},
      '{11'd0,   11'd2047, 1'b0, zero_a},
      '{11'd639, 11'd479, 1'b0, zero_a},
      '{11'd640, 11'd480, 1'b0, zero_a},
      '{11'd1092, 11'd240, 1'b0, zero_a},
      '{11'd1093, 11'd240, 1'b1, zero_a},
      '{11'd2047, 11'd0,   1'b1, zero_a},
      '{11'd2047, 11'd2047, 1'b1, zero_a},
      '{11'd1500, 11'd100, 1'b1, zero_a},
      '{11'd1, 11'd1, 1'b0, zero_a},
      '{11'd100, 11'd400, 1'b0, zero_a},
      '{11'd1024, 11'd1024, 1'b0, zero_a},
      '{11'd1365, 11'd682, 1'b0, zero_a},
      '{11'd682, 11'd1365, 1'b0, zero_a}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      fixed_flag.push_back(directed[i].fixed);
      if (directed[i].fixed) fixed_addr.push_back(directed[i].addr);
      send_pixel(directed[i].x, directed[i].y);
    end
    send_random(130);
    // Hold the sender until the pipe is empty before touching the registers.
    drain();

    for (int phase = 1; phase <= 8; phase++) begin
      set_pace(phase);
      case (phase)
        1: set_geometry(12'd1, 12'd1, 20'd256);
        2: set_geometry(12'd4095, 12'd4095, 20'd1048575);
        3: set_geometry(12'd2048, 12'd2048, 20'd0);
        4: set_geometry(12'd640, 12'd480, 20'd1);
        5: set_geometry(12'd2048, 12'd2048, 20'd197773);
        default: set_geometry(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                              20'($urandom_range(1, 1048575)));
      endcase
      send_random(phase == 3 ? 40 : 80);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
